@@ rtl/dbfm_pkg.sv @@
// ----------------------------------------------------------------------------
// dbfm_pkg: shared types and constants for the block free map allocator
// Item layouts, map entry layout, command codes, register indexes, the
// controller/datapath command and status bundles, and zone helpers.
// ----------------------------------------------------------------------------
package dbfm_pkg;

	// Command codes carried in the command field of an input item.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_ALLOC = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Configuration registers, selected by paddr[2] (4-byte stride).
	localparam int         PADDR_W             = 3;
	localparam logic       REG_DIRECTORY_TRACK = 1'b0;
	localparam logic       REG_TRACK_COUNT     = 1'b1;
	localparam logic [5:0] DIRECTORY_TRACK_RST = 6'd18;
	localparam logic [5:0] TRACK_COUNT_RST     = 6'd35;

	// Map geometry and limits.
	localparam int         SECTORS        = 24;
	localparam int         TOTAL_W        = 14;
	localparam logic [5:0] ALT_NEAR_TRACK = 6'd17;
	localparam logic [7:0] COUNT_MAX      = 8'd255;

	// Last track of each speed zone.
	localparam logic [6:0] ZONE1_LAST = 7'd17;
	localparam logic [6:0] ZONE2_LAST = 7'd24;
	localparam logic [6:0] ZONE3_LAST = 7'd30;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  track;
		logic [4:0]  sector;
		logic        mark_free;
		logic [7:0]  entry_count;
		logic [23:0] entry_bitmap;
	} req_item_t;

	typedef struct packed {
		logic               ok;
		logic               sector_free;
		logic [5:0]         alloc_track;
		logic [4:0]         alloc_sector;
		logic [TOTAL_W-1:0] free_total;
		logic               dirty;
	} rsp_item_t;

	// One word of the map memory.
	typedef struct packed {
		logic [7:0]  count;
		logic [23:0] bitmap;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic load_wr;
		logic entry_rd;
		logic entry_upd;
		logic alloc_start;
		logic alloc_rd;
		logic alloc_adv;
		logic alloc_take;
		logic sum_start;
		logic sum_step;
		logic out_load;
	} dbfm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] command;
		logic       trk_ok;
		logic       sec_ok;
		logic       loaded;
		logic       cand_valid;
		logic       search_done;
		logic       hit;
		logic       sum_done;
		logic       out_free;
	} dbfm_stat_t;

	// Sectors usable by allocation on a track, as a mask.
	function automatic logic [23:0] zone_mask(input logic [6:0] t);
		if (t <= ZONE1_LAST) begin
			return 24'h1FFFFF;
		end else if (t <= ZONE2_LAST) begin
			return 24'h07FFFF;
		end else if (t <= ZONE3_LAST) begin
			return 24'h03FFFF;
		end
		return 24'h01FFFF;
	endfunction

	// Lowest set bit of a free mask.
	function automatic logic [4:0] first_free(input logic [23:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = SECTORS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/dbfm_ram.sv @@
// ----------------------------------------------------------------------------
// dbfm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dbfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 35
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/dbfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbfm_ctrl: command sequencer for the block free map allocator
// Walks each item through dispatch, entry access or track search, the
// free total pass and the result hand-off, driving the datapath commands.
// ----------------------------------------------------------------------------
module dbfm_ctrl import dbfm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  dbfm_stat_t stat,
	output dbfm_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ENTRY_UPD,
		ST_A_SCAN,
		ST_A_CHK,
		ST_SUM_START,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_SUM_START;
				unique case (stat.command)
					CMD_LOAD: begin
						cmd.load_wr = stat.trk_ok;
					end
					CMD_SET, CMD_QUERY: begin
						if (stat.loaded && stat.trk_ok && stat.sec_ok) begin
							cmd.entry_rd = 1'b1;
							state_d      = ST_ENTRY_UPD;
						end
					end
					CMD_ALLOC: begin
						if (stat.loaded) begin
							cmd.alloc_start = 1'b1;
							state_d         = ST_A_SCAN;
						end
					end
					default: begin
						state_d = ST_SUM_START;
					end
				endcase
			end
			ST_ENTRY_UPD: begin
				cmd.entry_upd = 1'b1;
				state_d       = ST_SUM_START;
			end
			ST_A_SCAN: begin
				if (stat.search_done) begin
					state_d = ST_SUM_START;
				end else if (stat.cand_valid) begin
					cmd.alloc_rd = 1'b1;
					state_d      = ST_A_CHK;
				end else begin
					cmd.alloc_adv = 1'b1;
				end
			end
			ST_A_CHK: begin
				if (stat.hit) begin
					cmd.alloc_take = 1'b1;
					state_d        = ST_SUM_START;
				end else begin
					cmd.alloc_adv = 1'b1;
					state_d       = ST_A_SCAN;
				end
			end
			ST_SUM_START: begin
				cmd.sum_start = 1'b1;
				state_d       = ST_SUM;
			end
			ST_SUM: begin
				if (stat.sum_done) begin
					state_d = ST_OUT;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// New items are taken only between commands.
	assign req_stall = (state_q != ST_IDLE);

endmodule

@@ rtl/dbfm_datapath.sv @@
// ----------------------------------------------------------------------------
// dbfm_datapath: map memory, search counters and result register
// Holds the current item, the per-track map memory, the outward track
// search, the free total accumulator and the output register.
// ----------------------------------------------------------------------------
module dbfm_datapath import dbfm_pkg::*; #(
	parameter int MAX_TRACKS = 35
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_item_t  req,
	input  logic [5:0] directory_track,
	input  logic [5:0] track_count,
	input  dbfm_cmd_t  cmd,
	output dbfm_stat_t stat,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_item_t  rsp
);

	localparam int         AW      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam logic [5:0] MAX_TRK = 6'(MAX_TRACKS);

	req_item_t          item_q;
	logic               loaded_q;
	logic               dirty_q;
	logic               ok_q;
	logic               sfree_q;
	logic [5:0]         at_q;
	logic [4:0]         as_q;
	logic [5:0]         near_q;
	logic [5:0]         dist_q;
	logic               down_q;
	logic [5:0]         idx_q;
	logic               pend_s1;
	logic [TOTAL_W-1:0] acc_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic [5:0]  lim;
	logic        trk_ok;
	logic        near_ok;
	logic [6:0]  up_trk;
	logic [6:0]  dn_trk;
	logic [6:0]  cand_trk;
	logic        up_ok;
	logic        dn_ok;
	entry_t      rd_entry;
	logic [23:0] free_mask;
	logic [4:0]  hit_sec;
	logic        cur_bit;
	logic        changed;
	logic [7:0]  cnt_inc;
	logic [7:0]  cnt_dec;
	entry_t      set_entry;
	entry_t      take_entry;
	logic        sum_rd_en;
	logic        out_free;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	// Track limit and item checks.
	assign lim     = (track_count < MAX_TRK) ? track_count : MAX_TRK;
	assign trk_ok  = (item_q.track != 8'd0) && (item_q.track <= {2'b00, MAX_TRK});
	assign near_ok = (item_q.track != 8'd0) && (item_q.track <= {2'b00, lim});

	// Current search candidate: near + d on the up phase, near - d on the down phase.
	assign up_trk   = {1'b0, near_q} + {1'b0, dist_q};
	assign dn_trk   = {1'b0, near_q - dist_q};
	assign cand_trk = down_q ? dn_trk : up_trk;
	assign up_ok    = (up_trk <= {1'b0, lim}) && (up_trk != {1'b0, directory_track});
	assign dn_ok    = (dist_q != 6'd0) && (dist_q < near_q) &&
	                  (dn_trk <= {1'b0, lim}) && (dn_trk != {1'b0, directory_track});

	// Entry read back and the first free sector in the track's zone.
	assign rd_entry  = entry_t'(ram_rdata);
	assign free_mask = rd_entry.bitmap & zone_mask(cand_trk);
	assign hit_sec   = first_free(free_mask);

	// Saturating count updates.
	assign cnt_inc = (rd_entry.count == COUNT_MAX) ? COUNT_MAX : rd_entry.count + 8'd1;
	assign cnt_dec = (rd_entry.count == 8'd0) ? 8'd0 : rd_entry.count - 8'd1;

	// Set command: new bitmap bit and count.
	always_comb begin
		cur_bit   = rd_entry.bitmap[item_q.sector];
		changed   = (cur_bit != item_q.mark_free);
		set_entry = rd_entry;
		set_entry.bitmap[item_q.sector] = item_q.mark_free;
		set_entry.count = item_q.mark_free ? cnt_inc : cnt_dec;
	end

	// Allocation: the found sector becomes used.
	always_comb begin
		take_entry = rd_entry;
		take_entry.bitmap[hit_sec] = 1'b0;
		take_entry.count = cnt_dec;
	end

	assign sum_rd_en = (idx_q <= lim) && (idx_q != directory_track);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Memory port selection.
	always_comb begin
		ram_raddr = AW'(idx_q - 6'd1);
		if (cmd.entry_rd) begin
			ram_raddr = AW'(item_q.track - 8'd1);
		end else if (cmd.alloc_rd) begin
			ram_raddr = AW'(cand_trk - 7'd1);
		end
		ram_we    = 1'b0;
		ram_waddr = AW'(item_q.track - 8'd1);
		ram_wdata = set_entry;
		if (cmd.load_wr) begin
			ram_we    = 1'b1;
			ram_wdata = '{count: item_q.entry_count, bitmap: item_q.entry_bitmap};
		end else if (cmd.entry_upd) begin
			ram_we = (item_q.command == CMD_SET) && changed;
		end else if (cmd.alloc_take) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cand_trk - 7'd1);
			ram_wdata = take_entry;
		end
	end

	dbfm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_TRACKS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state: map flags, free total pass and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= 1'b0;
			dirty_q     <= 1'b0;
			pend_s1     <= 1'b0;
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_wr) begin
				loaded_q <= 1'b1;
				dirty_q  <= 1'b0;
			end
			if (cmd.entry_upd && (item_q.command == CMD_SET) && changed) begin
				dirty_q <= 1'b1;
			end
			if (cmd.alloc_take) begin
				dirty_q <= 1'b1;
			end
			if (cmd.sum_start) begin
				pend_s1 <= 1'b0;
				acc_q   <= '0;
			end else if (cmd.sum_step) begin
				pend_s1 <= sum_rd_en;
				if (pend_s1) begin
					acc_q <= acc_q + TOTAL_W'(rd_entry.count);
				end
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item, result fields, search and pass counters.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q  <= req;
			ok_q    <= 1'b0;
			sfree_q <= 1'b0;
			at_q    <= '0;
			as_q    <= '0;
		end
		if (cmd.load_wr) begin
			ok_q <= 1'b1;
		end
		if (cmd.entry_upd) begin
			ok_q    <= 1'b1;
			sfree_q <= (item_q.command == CMD_QUERY) && cur_bit;
		end
		if (cmd.alloc_start) begin
			near_q <= near_ok ? item_q.track[5:0] : ALT_NEAR_TRACK;
			dist_q <= '0;
			down_q <= 1'b0;
		end else if (cmd.alloc_adv) begin
			if (down_q) begin
				down_q <= 1'b0;
				dist_q <= dist_q + 6'd1;
			end else begin
				down_q <= 1'b1;
			end
		end
		if (cmd.alloc_take) begin
			ok_q <= 1'b1;
			at_q <= cand_trk[5:0];
			as_q <= hit_sec;
		end
		if (cmd.sum_start) begin
			idx_q <= 6'd1;
		end else if (cmd.sum_step && (idx_q <= lim)) begin
			idx_q <= idx_q + 6'd1;
		end
		if (cmd.out_load) begin
			rsp_q.ok           <= ok_q;
			rsp_q.sector_free  <= sfree_q;
			rsp_q.alloc_track  <= at_q;
			rsp_q.alloc_sector <= as_q;
			rsp_q.free_total   <= acc_q;
			rsp_q.dirty        <= dirty_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.command     = item_q.command;
		stat.trk_ok      = trk_ok;
		stat.sec_ok      = (item_q.sector < 5'(SECTORS));
		stat.loaded      = loaded_q;
		stat.cand_valid  = down_q ? dn_ok : up_ok;
		stat.search_done = (dist_q > lim);
		stat.hit         = |free_mask;
		stat.sum_done    = !loaded_q || ((idx_q > lim) && !pend_s1);
		stat.out_free    = out_free;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Once a map is loaded it stays loaded.
	a_loaded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |=> loaded_q)
		else $error("map loaded flag fell");

	// A load leaves the map loaded and clean.
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_wr |=> loaded_q && !dirty_q)
		else $error("load did not leave a clean loaded map");

	// Without a map the free total stays zero.
	a_total_unloaded: assert property (@(posedge clk) disable iff (!arst_n)
		!loaded_q |-> acc_q == '0)
		else $error("free total accumulated without a map");

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result register overwritten");

endmodule

@@ rtl/disk_block_free_map_allocator.sv @@
// ----------------------------------------------------------------------------
// disk_block_free_map_allocator: per-track block availability map
// Loads track entries, marks and queries sectors, allocates a free block
// near a preferred track and reports the free total after every command.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake             Content
//  req      in   req_valid/req_stall   command, track, sector, entry data
//  rsp      out  rsp_valid/rsp_stall   ok, query bit, allocated block, total
//  apb      in   psel/penable/pready   directory_track (0x0), track_count (0x4)
//
//  Items are handled one at a time. The free total pass reads one map entry
//  per cycle through the single read port; the search reads each valid
//  candidate track in ST_A_SCAN and ST_A_CHK and skips an invalid one in
//  ST_A_SCAN alone. Reset leaves no map loaded. A new item is taken while
//  the previous result waits; rsp_stall holds only the hand-off.
// ----------------------------------------------------------------------------
module disk_block_free_map_allocator import dbfm_pkg::*; #(
	parameter int MAX_TRACKS = 35
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_item_t          req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	logic [5:0] directory_track_q;
	logic [5:0] track_count_q;
	logic       reg_idx;
	dbfm_cmd_t  cmd;
	dbfm_stat_t stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directory_track_q <= DIRECTORY_TRACK_RST;
			track_count_q     <= TRACK_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_DIRECTORY_TRACK: directory_track_q <= pwdata[5:0];
				REG_TRACK_COUNT:     track_count_q     <= pwdata[5:0];
				default:             directory_track_q <= directory_track_q;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		unique case (reg_idx)
			REG_DIRECTORY_TRACK: prdata = {26'd0, directory_track_q};
			REG_TRACK_COUNT:     prdata = {26'd0, track_count_q};
			default:             prdata = '0;
		endcase
	end

	dbfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dbfm_datapath #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.directory_track (directory_track_q),
		.track_count     (track_count_q),
		.cmd             (cmd),
		.stat            (stat),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp)
	);

endmodule
